>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the instruction decoder.
// Concurrent checks on aclk; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RVD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("decoder assertion failed");
`define RVD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("decoder assertion failed");
`else
`define RVD_ASSERT(label, prop)
`define RVD_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> sv/rv64idec_pkg.sv
// Package for the RV64I instruction decoder: opcode, mnemonic and format
// codes and the packed decode result. No dependencies.
`timescale 1ns / 1ps

package rv64idec_pkg;

    localparam int INSTR_W = 32;
    localparam int MN_W    = 6;
    localparam int FMT_W   = 3;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 21;
    localparam int OUT_W   = 48;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] F7_ALT     = 7'b0100000;
    localparam logic [5:0] F6_SRA     = 6'b010000;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_R    = 3'd1;
    localparam logic [2:0] FMT_I    = 3'd2;
    localparam logic [2:0] FMT_S    = 3'd3;
    localparam logic [2:0] FMT_B    = 3'd4;
    localparam logic [2:0] FMT_U    = 3'd5;
    localparam logic [2:0] FMT_J    = 3'd6;

    localparam logic [5:0] MN_NONE   = 6'd0;
    localparam logic [5:0] MN_JAL    = 6'd1;
    localparam logic [5:0] MN_LUI    = 6'd2;
    localparam logic [5:0] MN_AUIPC  = 6'd3;
    localparam logic [5:0] MN_BEQ    = 6'd4;
    localparam logic [5:0] MN_BNE    = 6'd5;
    localparam logic [5:0] MN_BLT    = 6'd6;
    localparam logic [5:0] MN_BGE    = 6'd7;
    localparam logic [5:0] MN_BLTU   = 6'd8;
    localparam logic [5:0] MN_BGEU   = 6'd9;
    localparam logic [5:0] MN_SB     = 6'd10;
    localparam logic [5:0] MN_SH     = 6'd11;
    localparam logic [5:0] MN_SW     = 6'd12;
    localparam logic [5:0] MN_SD     = 6'd13;
    localparam logic [5:0] MN_ADDI   = 6'd14;
    localparam logic [5:0] MN_XORI   = 6'd15;
    localparam logic [5:0] MN_ORI    = 6'd16;
    localparam logic [5:0] MN_ANDI   = 6'd17;
    localparam logic [5:0] MN_SLLI   = 6'd18;
    localparam logic [5:0] MN_SRLI   = 6'd19;
    localparam logic [5:0] MN_SRAI   = 6'd20;
    localparam logic [5:0] MN_SLTI   = 6'd21;
    localparam logic [5:0] MN_SLTIU  = 6'd22;
    localparam logic [5:0] MN_LB     = 6'd23;
    localparam logic [5:0] MN_LH     = 6'd24;
    localparam logic [5:0] MN_LW     = 6'd25;
    localparam logic [5:0] MN_LD     = 6'd26;
    localparam logic [5:0] MN_LBU    = 6'd27;
    localparam logic [5:0] MN_LHU    = 6'd28;
    localparam logic [5:0] MN_LWU    = 6'd29;
    localparam logic [5:0] MN_JALR   = 6'd30;
    localparam logic [5:0] MN_ECALL  = 6'd31;
    localparam logic [5:0] MN_EBREAK = 6'd32;
    localparam logic [5:0] MN_ADD    = 6'd33;
    localparam logic [5:0] MN_SUB    = 6'd34;
    localparam logic [5:0] MN_XOR    = 6'd35;
    localparam logic [5:0] MN_OR     = 6'd36;
    localparam logic [5:0] MN_AND    = 6'd37;
    localparam logic [5:0] MN_SLL    = 6'd38;
    localparam logic [5:0] MN_SRL    = 6'd39;
    localparam logic [5:0] MN_SRA    = 6'd40;
    localparam logic [5:0] MN_SLT    = 6'd41;
    localparam logic [5:0] MN_SLTU   = 6'd42;
    localparam logic [5:0] MN_LAST   = MN_SLTU;

    typedef struct packed {
        logic [IMM_W-1:0] immediate;
        logic [REG_W-1:0] src_reg_two;
        logic [REG_W-1:0] src_reg_one;
        logic [REG_W-1:0] dest_reg;
        logic [FMT_W-1:0] format;
        logic [MN_W-1:0]  mnemonic;
    } result_t;

endpackage

>>> sv/rv64idec_decode.sv
// Combinational RV64I decode of one instruction word into a result_t.
// Depends on rv64idec_pkg.
`timescale 1ns / 1ps

module rv64idec_decode (
    input  logic [rv64idec_pkg::INSTR_W-1:0] instr,
    output rv64idec_pkg::result_t            result
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [11:0] i12;
    logic [rv64idec_pkg::IMM_W-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh;
    logic [rv64idec_pkg::MN_W-1:0]  mn;
    logic [rv64idec_pkg::FMT_W-1:0] fmt;
    logic [rv64idec_pkg::IMM_W-1:0] imm;
    logic use_rd, use_rs1, use_rs2;

    assign opc = instr[6:0];
    assign f3  = instr[14:12];
    assign f7  = instr[31:25];
    assign f6  = instr[31:26];
    assign i12 = instr[31:20];

    assign imm_i  = {{9{instr[31]}}, instr[31:20]};
    assign imm_s  = {{9{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b  = {{8{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_u  = {1'b0, instr[31:12]};
    assign imm_j  = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_sh = {16'd0, instr[24:20]};

    always_comb begin
        mn      = rv64idec_pkg::MN_NONE;
        fmt     = rv64idec_pkg::FMT_NONE;
        imm     = '0;
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        case (opc)
            rv64idec_pkg::OPC_OP: begin
                if (f7 == 7'd0) begin
                    case (f3)
                        3'd0:    mn = rv64idec_pkg::MN_ADD;
                        3'd1:    mn = rv64idec_pkg::MN_SLL;
                        3'd2:    mn = rv64idec_pkg::MN_SLT;
                        3'd3:    mn = rv64idec_pkg::MN_SLTU;
                        3'd4:    mn = rv64idec_pkg::MN_XOR;
                        3'd5:    mn = rv64idec_pkg::MN_SRL;
                        3'd6:    mn = rv64idec_pkg::MN_OR;
                        default: mn = rv64idec_pkg::MN_AND;
                    endcase
                end else if (f7 == rv64idec_pkg::F7_ALT && f3 == 3'd0) begin
                    mn = rv64idec_pkg::MN_SUB;
                end else if (f7 == rv64idec_pkg::F7_ALT && f3 == 3'd5) begin
                    mn = rv64idec_pkg::MN_SRA;
                end
                fmt = rv64idec_pkg::FMT_R;
                use_rd = 1'b1; use_rs1 = 1'b1; use_rs2 = 1'b1;
            end
            rv64idec_pkg::OPC_OP_IMM: begin
                case (f3)
                    3'd0: mn = rv64idec_pkg::MN_ADDI;
                    3'd1: mn = (f6 == 6'd0) ? rv64idec_pkg::MN_SLLI : rv64idec_pkg::MN_NONE;
                    3'd2: mn = rv64idec_pkg::MN_SLTI;
                    3'd3: mn = rv64idec_pkg::MN_SLTIU;
                    3'd4: mn = rv64idec_pkg::MN_XORI;
                    3'd5: begin
                        if (f6 == 6'd0)
                            mn = rv64idec_pkg::MN_SRLI;
                        else if (f6 == rv64idec_pkg::F6_SRA)
                            mn = rv64idec_pkg::MN_SRAI;
                    end
                    3'd6:    mn = rv64idec_pkg::MN_ORI;
                    default: mn = rv64idec_pkg::MN_ANDI;
                endcase
                imm = (f3 == 3'd1 || f3 == 3'd5) ? imm_sh : imm_i;
                fmt = rv64idec_pkg::FMT_I;
                use_rd = 1'b1; use_rs1 = 1'b1;
            end
            rv64idec_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0:    mn = rv64idec_pkg::MN_LB;
                    3'd1:    mn = rv64idec_pkg::MN_LH;
                    3'd2:    mn = rv64idec_pkg::MN_LW;
                    3'd3:    mn = rv64idec_pkg::MN_LD;
                    3'd4:    mn = rv64idec_pkg::MN_LBU;
                    3'd5:    mn = rv64idec_pkg::MN_LHU;
                    3'd6:    mn = rv64idec_pkg::MN_LWU;
                    default: mn = rv64idec_pkg::MN_NONE;
                endcase
                imm = imm_i;
                fmt = rv64idec_pkg::FMT_I;
                use_rd = 1'b1; use_rs1 = 1'b1;
            end
            rv64idec_pkg::OPC_JALR: begin
                if (f3 == 3'd0)
                    mn = rv64idec_pkg::MN_JALR;
                imm = imm_i;
                fmt = rv64idec_pkg::FMT_I;
                use_rd = 1'b1; use_rs1 = 1'b1;
            end
            rv64idec_pkg::OPC_SYSTEM: begin
                if (f3 == 3'd0 && i12 == 12'd0)
                    mn = rv64idec_pkg::MN_ECALL;
                else if (f3 == 3'd0 && i12 == 12'd1)
                    mn = rv64idec_pkg::MN_EBREAK;
                imm = imm_i;
                fmt = rv64idec_pkg::FMT_I;
                use_rd = 1'b1; use_rs1 = 1'b1;
            end
            rv64idec_pkg::OPC_STORE: begin
                case (f3)
                    3'd0:    mn = rv64idec_pkg::MN_SB;
                    3'd1:    mn = rv64idec_pkg::MN_SH;
                    3'd2:    mn = rv64idec_pkg::MN_SW;
                    3'd3:    mn = rv64idec_pkg::MN_SD;
                    default: mn = rv64idec_pkg::MN_NONE;
                endcase
                imm = imm_s;
                fmt = rv64idec_pkg::FMT_S;
                use_rs1 = 1'b1; use_rs2 = 1'b1;
            end
            rv64idec_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0:    mn = rv64idec_pkg::MN_BEQ;
                    3'd1:    mn = rv64idec_pkg::MN_BNE;
                    3'd4:    mn = rv64idec_pkg::MN_BLT;
                    3'd5:    mn = rv64idec_pkg::MN_BGE;
                    3'd6:    mn = rv64idec_pkg::MN_BLTU;
                    3'd7:    mn = rv64idec_pkg::MN_BGEU;
                    default: mn = rv64idec_pkg::MN_NONE;
                endcase
                imm = imm_b;
                fmt = rv64idec_pkg::FMT_B;
                use_rs1 = 1'b1; use_rs2 = 1'b1;
            end
            rv64idec_pkg::OPC_LUI: begin
                mn = rv64idec_pkg::MN_LUI;
                imm = imm_u;
                fmt = rv64idec_pkg::FMT_U;
                use_rd = 1'b1;
            end
            rv64idec_pkg::OPC_AUIPC: begin
                mn = rv64idec_pkg::MN_AUIPC;
                imm = imm_u;
                fmt = rv64idec_pkg::FMT_U;
                use_rd = 1'b1;
            end
            rv64idec_pkg::OPC_JAL: begin
                mn = rv64idec_pkg::MN_JAL;
                imm = imm_j;
                fmt = rv64idec_pkg::FMT_J;
                use_rd = 1'b1;
            end
            default: begin
                mn = rv64idec_pkg::MN_NONE;
            end
        endcase

        // drop everything for an unrecognized word
        if (mn == rv64idec_pkg::MN_NONE) begin
            fmt     = rv64idec_pkg::FMT_NONE;
            imm     = '0;
            use_rd  = 1'b0;
            use_rs1 = 1'b0;
            use_rs2 = 1'b0;
        end
    end

    assign result.mnemonic    = mn;
    assign result.format      = fmt;
    assign result.dest_reg    = use_rd  ? instr[11:7]  : 5'd0;
    assign result.src_reg_one = use_rs1 ? instr[19:15] : 5'd0;
    assign result.src_reg_two = use_rs2 ? instr[24:20] : 5'd0;
    assign result.immediate   = imm;

endmodule

>>> sv/rv64i_instruction_decoder_unit.sv
// Top level of the RV64I instruction decoder: input word register, decode
// core and result register. Depends on rv64idec_pkg, rv64idec_decode and
// assert_macros.svh.
//
// Usage:
//   Slave channel s_tvalid/s_tready/s_tdata carries one 32-bit instruction
//   word per transfer. Master channel m_tvalid/m_tready/m_tdata carries one
//   decode word per instruction, fields from the lowest bit up: mnemonic
//   [5:0], format [8:6], dest_reg [13:9], src_reg_one [18:14],
//   src_reg_two [23:19], immediate [44:24] (two's complement), zeros [47:45].
//   m_tvalid rises once the word has passed from the input register through
//   the decode logic into the result register; the result register takes it
//   only while it is empty or its word is being taken by the receiver.
//   Throughput is one word per cycle while m_tready stays high; the decode
//   is a single combinational pass between the two registers.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word, so two words are buffered
//   before s_tready drops. Reset (aresetn low, synchronous) empties both
//   registers; no word is in flight afterwards.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rv64i_instruction_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // instruction [31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // mnemonic, format, dest_reg, src_reg_one,
                                   // src_reg_two, immediate, zero pad
);

    logic                       in_valid_reg;
    logic [31:0]                instr_reg;
    logic                       out_valid_reg;
    rv64idec_pkg::result_t      result_reg;
    rv64idec_pkg::result_t      result_next;
    logic                       out_free;
    logic                       in_advance;

    assign out_free   = !out_valid_reg || m_tready;
    assign in_advance = in_valid_reg && out_free;
    assign s_tready   = !in_valid_reg || out_free;

    rv64idec_decode u_decode (
        .instr  (instr_reg),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid)
            instr_reg <= s_tdata;
        if (in_advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, result_reg};

    `RVD_ASSERT(a_stall_holds_input, in_valid_reg && !out_free |=> in_valid_reg)
    `RVD_ASSERT(a_unknown_all_zero,
        out_valid_reg && result_reg.mnemonic == rv64idec_pkg::MN_NONE |->
        result_reg.format == rv64idec_pkg::FMT_NONE && result_reg.immediate == '0 &&
        result_reg.dest_reg == '0 && result_reg.src_reg_one == '0 &&
        result_reg.src_reg_two == '0)
    `RVD_ASSERT(a_mnemonic_range, out_valid_reg |-> result_reg.mnemonic <= rv64idec_pkg::MN_LAST)
    `RVD_ASSERT(a_no_rd_store_branch,
        out_valid_reg && (result_reg.format == rv64idec_pkg::FMT_S ||
        result_reg.format == rv64idec_pkg::FMT_B) |-> result_reg.dest_reg == '0)
    `RVD_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid && s_tready)

endmodule

>>> bench/rv64i_instruction_decoder_unit_tb.sv
// Testbench for rv64i_instruction_decoder_unit: drives instruction words, predicts
// each decode word and checks the results field by field under random idling.
// Depends on rv64idec_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module rv64i_instruction_decoder_unit_tb;
    import rv64idec_pkg::*;

    localparam logic [2:0]  F3_BASE    = 3'd0;
    localparam logic [2:0]  F3_SHL     = 3'd1;
    localparam logic [2:0]  F3_HOLE    = 3'd2;
    localparam logic [2:0]  F3_SHR     = 3'd5;
    localparam logic [11:0] SYS_ECALL  = 12'd0;
    localparam logic [11:0] SYS_EBREAK = 12'd1;
    localparam int          MAX_GAP    = 18;
    localparam int          MAX_LINES  = 40;

    localparam logic [7:0][5:0] OP_BY_F3 =
        {MN_AND, MN_OR, MN_SRL, MN_XOR, MN_SLTU, MN_SLT, MN_SLL, MN_ADD};
    localparam logic [7:0][5:0] OPIMM_BY_F3 =
        {MN_ANDI, MN_ORI, MN_NONE, MN_XORI, MN_SLTIU, MN_SLTI, MN_NONE, MN_ADDI};
    localparam logic [7:0][5:0] LOAD_BY_F3 =
        {MN_NONE, MN_LWU, MN_LHU, MN_LBU, MN_LD, MN_LW, MN_LH, MN_LB};
    localparam logic [7:0][5:0] STORE_BY_F3 =
        {MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_SD, MN_SW, MN_SH, MN_SB};
    localparam logic [7:0][5:0] BRANCH_BY_F3 =
        {MN_BGEU, MN_BLTU, MN_BGE, MN_BLT, MN_NONE, MN_NONE, MN_BNE, MN_BEQ};
    localparam logic [9:0][6:0] KNOWN_OPCODES =
        {OPC_OP, OPC_OP_IMM, OPC_LOAD, OPC_STORE, OPC_BRANCH,
         OPC_JAL, OPC_JALR, OPC_LUI, OPC_AUIPC, OPC_SYSTEM};

    typedef struct {
        logic [31:0] instr;
        result_t     want;
    } pending_decode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    pending_decode_t decode_queue[$];
    int              fail_count     = 0;
    int              sink_wait      = 0;
    bit              src_no_gaps    = 1'b0;
    bit              sink_no_stalls = 1'b0;

    rv64i_instruction_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic result_t decode_instr(logic [31:0] w);
        result_t     r;
        logic [11:0] i12;
        logic [20:0] i_ext;
        logic [12:0] b_off;
        logic [20:0] j_off;
        logic        use_rd;
        logic        use_rs1;
        logic        use_rs2;
        r       = '0;
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        i12     = w[31:20];
        i_ext   = {{9{i12[11]}}, i12};
        b_off   = {w[31], w[7], w[30:25], w[11:8], 1'b0};
        j_off   = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        case (w[6:0])
            OPC_OP: begin
                if (w[31:25] == 7'd0)
                    r.mnemonic = OP_BY_F3[w[14:12]];
                else if (w[31:25] == F7_ALT && w[14:12] == F3_BASE)
                    r.mnemonic = MN_SUB;
                else if (w[31:25] == F7_ALT && w[14:12] == F3_SHR)
                    r.mnemonic = MN_SRA;
                r.format = FMT_R;
                {use_rd, use_rs1, use_rs2} = 3'b111;
            end
            OPC_OP_IMM: begin
                if (w[14:12] == F3_SHL) begin
                    if (w[31:26] == 6'd0) r.mnemonic = MN_SLLI;
                    r.immediate = {16'd0, w[24:20]};
                end else if (w[14:12] == F3_SHR) begin
                    if (w[31:26] == 6'd0) r.mnemonic = MN_SRLI;
                    else if (w[31:26] == F6_SRA) r.mnemonic = MN_SRAI;
                    r.immediate = {16'd0, w[24:20]};
                end else begin
                    r.mnemonic  = OPIMM_BY_F3[w[14:12]];
                    r.immediate = i_ext;
                end
                r.format = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_LOAD: begin
                r.mnemonic  = LOAD_BY_F3[w[14:12]];
                r.immediate = i_ext;
                r.format    = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_JALR: begin
                if (w[14:12] == F3_BASE) r.mnemonic = MN_JALR;
                r.immediate = i_ext;
                r.format    = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_SYSTEM: begin
                if (w[14:12] == F3_BASE && i12 == SYS_ECALL) r.mnemonic = MN_ECALL;
                else if (w[14:12] == F3_BASE && i12 == SYS_EBREAK) r.mnemonic = MN_EBREAK;
                r.immediate = i_ext;
                r.format    = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_STORE: begin
                r.mnemonic  = STORE_BY_F3[w[14:12]];
                r.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
                r.format    = FMT_S;
                {use_rs1, use_rs2} = 2'b11;
            end
            OPC_BRANCH: begin
                r.mnemonic  = BRANCH_BY_F3[w[14:12]];
                r.immediate = {{8{b_off[12]}}, b_off};
                r.format    = FMT_B;
                {use_rs1, use_rs2} = 2'b11;
            end
            OPC_LUI, OPC_AUIPC: begin
                r.mnemonic  = (w[6:0] == OPC_LUI) ? MN_LUI : MN_AUIPC;
                r.immediate = {1'b0, w[31:12]};
                r.format    = FMT_U;
                use_rd      = 1'b1;
            end
            OPC_JAL: begin
                r.mnemonic  = MN_JAL;
                r.immediate = j_off;
                r.format    = FMT_J;
                use_rd      = 1'b1;
            end
            default: ;
        endcase
        if (r.mnemonic == MN_NONE) return '0;
        r.dest_reg    = use_rd  ? w[11:7]  : '0;
        r.src_reg_one = use_rs1 ? w[19:15] : '0;
        r.src_reg_two = use_rs2 ? w[24:20] : '0;
        return r;
    endfunction

    // Force opcode and function bits of a raw word so it encodes the given mnemonic.
    function automatic logic [31:0] shape_word(logic [5:0] mn, logic [31:0] w);
        for (int k = 0; k < 8; k++) begin
            if (OP_BY_F3[k] == mn) begin
                w[6:0]   = OPC_OP;
                w[14:12] = k[2:0];
                w[31:25] = 7'd0;
            end
            if (OPIMM_BY_F3[k] == mn) begin
                w[6:0]   = OPC_OP_IMM;
                w[14:12] = k[2:0];
            end
            if (LOAD_BY_F3[k] == mn) begin
                w[6:0]   = OPC_LOAD;
                w[14:12] = k[2:0];
            end
            if (STORE_BY_F3[k] == mn) begin
                w[6:0]   = OPC_STORE;
                w[14:12] = k[2:0];
            end
            if (BRANCH_BY_F3[k] == mn) begin
                w[6:0]   = OPC_BRANCH;
                w[14:12] = k[2:0];
            end
        end
        case (mn)
            MN_SUB, MN_SRA: begin
                w[6:0]   = OPC_OP;
                w[14:12] = (mn == MN_SUB) ? F3_BASE : F3_SHR;
                w[31:25] = F7_ALT;
            end
            MN_SLLI, MN_SRLI, MN_SRAI: begin
                w[6:0]   = OPC_OP_IMM;
                w[14:12] = (mn == MN_SLLI) ? F3_SHL : F3_SHR;
                w[31:26] = (mn == MN_SRAI) ? F6_SRA : 6'd0;
            end
            MN_JALR: begin
                w[6:0]   = OPC_JALR;
                w[14:12] = F3_BASE;
            end
            MN_ECALL, MN_EBREAK: begin
                w[6:0]   = OPC_SYSTEM;
                w[14:12] = F3_BASE;
                w[31:20] = (mn == MN_ECALL) ? SYS_ECALL : SYS_EBREAK;
            end
            MN_LUI:   w[6:0] = OPC_LUI;
            MN_AUIPC: w[6:0] = OPC_AUIPC;
            MN_JAL:   w[6:0] = OPC_JAL;
            default: ;
        endcase
        return w;
    endfunction

    function automatic int pick_gap(bit no_gaps);
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= MAX_LINES) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] instr, logic [20:0] got,
                               logic [20:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %h %s got %h want %h", instr, name, got, want));
    endtask

    // Hold the word until the decoder takes it; valid stays high for a following word.
    task automatic send_word(logic [31:0] w);
        int gap;
        gap = pick_gap(src_no_gaps);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : sink_side
        int stall;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                stall = pick_gap(sink_no_stalls);
                if (stall != 0) begin
                    m_tready  <= 1'b0;
                    sink_wait <= stall;
                end
            end
        end else if (sink_wait <= 1) begin
            m_tready <= 1'b1;
        end else begin
            sink_wait <= sink_wait - 1;
        end
    end

    always @(posedge aclk) begin : watch_words
        pending_decode_t item;
        result_t         got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                item.instr = s_tdata;
                item.want  = decode_instr(s_tdata);
                decode_queue.push_back(item);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[44:0]);
                if (decode_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_tdata));
                end else begin
                    item = decode_queue.pop_front();
                    check_field("mnemonic", item.instr, got.mnemonic, item.want.mnemonic);
                    check_field("format", item.instr, got.format, item.want.format);
                    check_field("dest_reg", item.instr, got.dest_reg, item.want.dest_reg);
                    check_field("src_reg_one", item.instr, got.src_reg_one,
                                item.want.src_reg_one);
                    check_field("src_reg_two", item.instr, got.src_reg_two,
                                item.want.src_reg_two);
                    check_field("immediate", item.instr, got.immediate, item.want.immediate);
                    check_field("pad", item.instr, m_tdata[47:45], 3'd0);
                end
            end
        end
    end

    task automatic test_directed_cases();
        logic [31:0] w;
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(shape_word(MN_ADD, 32'hFFFF_FFFF));
        send_word(shape_word(MN_SUB, 32'h0000_0000));
        send_word(shape_word(MN_SRA, 32'hFFFF_FFFF));
        w = shape_word(MN_SLL, 32'hFFFF_FFFF);
        w[31:25] = F7_ALT;
        send_word(w);
        send_word(shape_word(MN_ADDI, 32'h8000_0000));
        send_word(shape_word(MN_SLTIU, 32'h7FF0_0000));
        // bit 25 of a shift immediate is ignored
        send_word(shape_word(MN_SLLI, 32'h03F0_0000));
        send_word(shape_word(MN_SRAI, 32'hFFFF_FFFF));
        w = shape_word(MN_SRLI, 32'hFFFF_FFFF);
        w[31:26] = ~F6_SRA;
        send_word(w);
        w = shape_word(MN_SLLI, 32'h0000_0000);
        w[31:26] = F6_SRA;
        send_word(w);
        send_word(shape_word(MN_LD, 32'h8000_0000));
        w = shape_word(MN_LB, 32'hFFFF_FFFF);
        w[14:12] = ~F3_BASE;
        send_word(w);
        send_word(shape_word(MN_SD, 32'hFE00_0F80));
        w = shape_word(MN_SB, 32'hFFFF_FFFF);
        w[14:12] = F3_SHR;
        send_word(w);
        send_word(shape_word(MN_BEQ, 32'h8000_0000));
        send_word(shape_word(MN_BGEU, 32'h7E00_0F80));
        w = shape_word(MN_BEQ, 32'hFFFF_FFFF);
        w[14:12] = F3_HOLE;
        send_word(w);
        send_word(shape_word(MN_JAL, 32'h8000_0000));
        send_word(shape_word(MN_JAL, 32'h7FFF_F000));
        send_word(shape_word(MN_LUI, 32'hFFFF_FFFF));
        send_word(shape_word(MN_AUIPC, 32'h0000_0000));
        send_word(shape_word(MN_ECALL, 32'hFFFF_FFFF));
        send_word(shape_word(MN_EBREAK, 32'h0000_0000));
        w = shape_word(MN_ECALL, 32'h0000_0000);
        w[31:20] = SYS_EBREAK + 12'd1;
        send_word(w);
        w = shape_word(MN_JALR, 32'hFFFF_FFFF);
        w[14:12] = F3_SHL;
        send_word(w);
    endtask

    task automatic test_each_mnemonic();
        for (int m = MN_JAL; m <= MN_LAST; m++)
            send_word(shape_word(m[5:0], $urandom()));
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          roll;
        int          pos;
        roll = $urandom_range(0, 99);
        w    = $urandom();
        if (roll < 70) begin
            w = shape_word(6'($urandom_range(MN_JAL, MN_LAST)), w);
        end else if (roll < 80) begin
            w[6:0] = KNOWN_OPCODES[$urandom_range(0, 9)];
        end else if (roll < 92) begin
            // flip one function bit of a valid encoding
            w   = shape_word(6'($urandom_range(MN_JAL, MN_LAST)), w);
            pos = $urandom_range(0, 9);
            pos = (pos < 3) ? 12 + pos : 22 + pos;
            w[pos] = ~w[pos];
        end
        return w;
    endfunction

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                src_no_gaps    = ($urandom_range(0, 3) == 0);
                sink_no_stalls = ($urandom_range(0, 3) == 0);
            end
            send_word(random_word());
        end
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
    endtask

    task automatic test_back_to_back(int count);
        src_no_gaps    = 1'b1;
        sink_no_stalls = 1'b1;
        for (int i = 0; i < count; i++) send_word(random_word());
        // receiver backpressure against a full-rate sender
        sink_no_stalls = 1'b0;
        for (int i = 0; i < count; i++) send_word(random_word());
        src_no_gaps = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_each_mnemonic();
        test_random_mix(1000);
        test_back_to_back(90);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (decode_queue.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (decode_queue.size() != 0)
            report_mismatch($sformatf("%0d decode words never arrived", decode_queue.size()));
        if (fail_count == 0) begin
            $display("rv64i_instruction_decoder_unit_tb: PASS");
        end else begin
            $display("rv64i_instruction_decoder_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("rv64i_instruction_decoder_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/rv64idec_pkg.sv
sv/rv64idec_decode.sv
sv/rv64i_instruction_decoder_unit.sv
bench/rv64i_instruction_decoder_unit_tb.sv
